FILE: design/assert_macros.svh
// Concurrent check helpers, clocked on clk and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every edge
`define CHK_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/bft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bft_pkg;

  localparam int CH_W       = 16;
  localparam int POS_W      = 8;
  localparam int SPACE_W    = 16;
  localparam int COLOR_W    = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam int EXP_DEPTH  = 1024;
  localparam int EW         = 10;
  localparam int EXP_VAL_W  = 17;
  localparam int DIV_STEPS  = 16;

  localparam logic [63:0] EXP_STEP   = 64'd1057095000;
  localparam logic [63:0] COLOR_C    = 64'd4294836225;
  localparam logic [63:0] COLOR_D    = 64'd274869518400;
  localparam logic [63:0] COLOR_HALF = 64'd137434759200;
  localparam logic [63:0] BIG_LIMIT  = 64'(EXP_DEPTH) * COLOR_D;

  localparam logic [POS_W-1:0]   TILE_LAST_RST   = 8'd63;
  localparam logic [SPACE_W-1:0] SPACE_SCALE_RST = 16'd1693;
  localparam logic [COLOR_W-1:0] COLOR_SCALE_RST = 20'd80000;
  localparam logic [CH_W-1:0]    CHAN_MAX        = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILE_LAST   = 2'd0,
    CFG_SPACE_SCALE = 2'd1,
    CFG_COLOR_SCALE = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTER,
    ST_TAPS,
    ST_FLUSH,
    ST_DIV_INIT,
    ST_DIV,
    ST_LOAD
  } fsm_state_t;

  typedef logic [EXP_VAL_W-1:0] exp_rom_t [EXP_DEPTH];

  function automatic exp_rom_t build_exp_rom();
    logic [63:0] acc;
    exp_rom_t rom;
    acc = 64'd1 << 30;
    for (int i = 0; i < EXP_DEPTH; i++) begin
      rom[i] = EXP_VAL_W'((acc + 64'd8192) >> 14);
      acc = (acc * EXP_STEP + (64'd1 << 29)) >> 30;
    end
    return rom;
  endfunction

endpackage
`default_nettype wire

FILE: design/bilateral_filter_rgba_tile_top.sv
// Pixel item that emits nothing, or an ignored item: transfer taken while the block stays idle.
// Emitting item: 1 center read, one tap per cycle over the window ((2R+1)^2 taps),
// a 10-stage weight/accumulate pipeline, then a 16-step divide on four lanes;
// the input stays stalled until the result is loaded into the output register.
// Reset (synchronous) clears the tile counters, loads register defaults;
// row ring contents stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bilateral_filter_rgba_tile_top #(
  parameter int MAX_TILE_WIDTH = 256,
  parameter int WINDOW_RADIUS  = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [bft_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bft_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           kind,
  input  wire logic [bft_pkg::CH_W-1:0]       red,
  input  wire logic [bft_pkg::CH_W-1:0]       green,
  input  wire logic [bft_pkg::CH_W-1:0]       blue,
  input  wire logic [bft_pkg::CH_W-1:0]       alpha,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [bft_pkg::CH_W-1:0]            out_red,
  output logic [bft_pkg::CH_W-1:0]            out_green,
  output logic [bft_pkg::CH_W-1:0]            out_blue,
  output logic [bft_pkg::CH_W-1:0]            out_alpha,
  output logic [bft_pkg::POS_W-1:0]           pixel_row,
  output logic [bft_pkg::POS_W-1:0]           pixel_col,
  output logic                                tile_done
);
  import bft_pkg::*;

  localparam int WIN    = 2 * WINDOW_RADIUS + 1;
  localparam int SLOTS  = WIN + 1;
  localparam int TAPS   = WIN * WIN;
  localparam int CW     = $clog2(MAX_TILE_WIDTH);
  localparam int SW     = $clog2(SLOTS);
  localparam int AW     = SW + CW;
  localparam int DW     = $clog2(2 * WINDOW_RADIUS * WINDOW_RADIUS + 1);
  localparam int SUM_W  = 32 + $clog2(TAPS);
  localparam int WS     = 17 + $clog2(TAPS);
  localparam int NW     = SUM_W + 1;
  localparam int YW     = EW + 32;
  localparam int SP_W   = DW + SPACE_W;
  localparam exp_rom_t EXP_ROM = build_exp_rom();

  fsm_state_t state, state_next;

  logic [POS_W-1:0]   tile_last;
  logic [SPACE_W-1:0] space_scale;
  logic [COLOR_W-1:0] color_scale;
  logic [POS_W-1:0]   last;

  logic [POS_W-1:0] in_row, in_col, out_row, out_col;
  logic [SW-1:0]    in_slot, out_slot;
  logic             tile_loaded;

  logic [POS_W-1:0] f_row, f_col;
  logic [SW-1:0]    f_slot;
  logic             f_done;

  logic [SW-1:0] tv, tu;
  logic          tap_last;

  logic [4*CH_W-1:0] ring [SLOTS * (2 ** CW)];
  logic [4*CH_W-1:0] ring_q;
  logic [AW-1:0]     rd_addr, tap_addr;
  logic [4*CH_W-1:0] ctr;

  logic in_acc, do_pix, do_drain, pix_emit, emit;
  logic in_end, out_end;

  // tap geometry
  logic signed [POS_W+2:0] rsum, csum;
  logic [POS_W-1:0]        rr, cc;
  logic signed [POS_W+2:0] drow;
  logic signed [SW+1:0]    sraw;
  logic [SW-1:0]           tslot;
  logic signed [SW:0]      dvs, dus;
  logic [DW-1:0]           tap_dist;

  // pipeline
  logic v0, va, vb, vc, vd, ve, vf, vg, vh, vi;
  logic [DW-1:0]     dist0;
  logic [31:0]       sq_a [3];
  logic [SP_W-1:0]   sprod_a;
  logic [4*CH_W-1:0] nb_a, nb_b, nb_c, nb_d, nb_e, nb_f, nb_g, nb_h;
  logic [33:0]       d2_b;
  logic [SP_W-6:0]   sfull;
  logic [EW-1:0]     sidx_b, sidx_c, sidx_d, sidx_e;
  logic              s_ok_b, s_ok_c, s_ok_d, s_ok_e;
  logic [53:0]       cprod_c;
  logic [63:0]       x_full;
  logic [YW-1:0]     y_d, y_e, r_e;
  logic [EW-1:0]     q0_d, q0_e;
  logic              big_d, big_e;
  logic [YW-1:0]     qc_e;
  logic [EW:0]       q_e;
  logic              c_ok;
  logic [EXP_VAL_W-1:0] exp_s_f, exp_c_f;
  logic [33:0]       wprod_g;
  logic [16:0]       w_h, w_i;
  logic [32:0]       prod_i [4];
  logic [SUM_W-1:0]  sum_acc [4];
  logic [WS-1:0]     wsum;
  logic              pipe_busy;

  // divider
  logic [WS-1:0]   dw;
  logic [WS-1:0]   wfl;
  logic [NW-1:0]   n_val [4];
  logic [WS-1:0]   rem [4];
  logic [WS:0]     rem2 [4];
  logic            ge [4];
  logic [CH_W-1:0] nlow [4];
  logic [CH_W-1:0] quot [4];
  logic            sat [4];
  logic [3:0]      div_cnt;
  logic            load_go;

  assign last = (32'(tile_last) > MAX_TILE_WIDTH - 1) ? POS_W'(MAX_TILE_WIDTH - 1) : tile_last;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign do_pix    = in_acc && !kind && !tile_loaded;
  assign do_drain  = in_acc && kind && tile_loaded;
  assign pix_emit  = do_pix && ((in_row > POS_W'(WINDOW_RADIUS)) ||
                     ((in_row == POS_W'(WINDOW_RADIUS)) && (in_col >= POS_W'(WINDOW_RADIUS))));
  assign emit      = do_drain || pix_emit;
  assign in_end    = (in_row == last) && (in_col == last);
  assign out_end   = (out_row == last) && (out_col == last);
  assign tap_last  = (tv == SW'(WIN - 1)) && (tu == SW'(WIN - 1));
  assign load_go   = (state == ST_LOAD) && (!out_valid || !out_stall);

  always_comb begin
    rsum = $signed({3'b000, f_row}) + $signed((POS_W+3)'(tv)) - $signed((POS_W+3)'(WINDOW_RADIUS));
    csum = $signed({3'b000, f_col}) + $signed((POS_W+3)'(tu)) - $signed((POS_W+3)'(WINDOW_RADIUS));
    if (rsum < 0) begin
      rr = '0;
    end else if (rsum > $signed({3'b000, last})) begin
      rr = last;
    end else begin
      rr = rsum[POS_W-1:0];
    end
    if (csum < 0) begin
      cc = '0;
    end else if (csum > $signed({3'b000, last})) begin
      cc = last;
    end else begin
      cc = csum[POS_W-1:0];
    end
    drow = $signed({3'b000, rr}) - $signed({3'b000, f_row});
    sraw = $signed({2'b00, f_slot}) + $signed((SW+2)'(drow));
    if (sraw < 0) begin
      tslot = SW'(sraw + $signed((SW+2)'(SLOTS)));
    end else if (sraw >= $signed((SW+2)'(SLOTS))) begin
      tslot = SW'(sraw - $signed((SW+2)'(SLOTS)));
    end else begin
      tslot = SW'(sraw);
    end
    tap_addr = {tslot, CW'(cc)};
    dvs  = $signed({1'b0, tv}) - $signed((SW+1)'(WINDOW_RADIUS));
    dus  = $signed({1'b0, tu}) - $signed((SW+1)'(WINDOW_RADIUS));
    tap_dist = DW'(dvs * dvs + dus * dus);
    rd_addr = (state == ST_CENTER) ? {f_slot, CW'(f_col)} : tap_addr;
  end

  always_ff @(posedge clk) begin
    if (do_pix) begin
      ring[{in_slot, CW'(in_col)}] <= {alpha, blue, green, red};
    end
    ring_q <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (emit) state_next = ST_CENTER;
      ST_CENTER:   state_next = ST_TAPS;
      ST_TAPS:     if (tap_last) state_next = ST_FLUSH;
      ST_FLUSH:    if (!pipe_busy) state_next = ST_DIV_INIT;
      ST_DIV_INIT: state_next = ST_DIV;
      ST_DIV:      if (div_cnt == 4'(DIV_STEPS - 1)) state_next = ST_LOAD;
      ST_LOAD:     if (load_go) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // tile counters and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tile_last   <= TILE_LAST_RST;
      space_scale <= SPACE_SCALE_RST;
      color_scale <= COLOR_SCALE_RST;
      in_row <= '0; in_col <= '0; in_slot <= '0;
      out_row <= '0; out_col <= '0; out_slot <= '0;
      tile_loaded <= 1'b0;
    end else begin
      if (do_pix) begin
        if (in_end) begin
          tile_loaded <= 1'b1;
          in_row <= '0; in_col <= '0; in_slot <= '0;
        end else if (in_col >= last) begin
          in_col  <= '0;
          in_row  <= in_row + 1'b1;
          in_slot <= (in_slot == SW'(SLOTS - 1)) ? '0 : in_slot + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
      end
      if (emit) begin
        if (out_end) begin
          in_row <= '0; in_col <= '0; in_slot <= '0;
          out_row <= '0; out_col <= '0; out_slot <= '0;
          tile_loaded <= 1'b0;
        end else if (out_col >= last) begin
          out_col  <= '0;
          out_row  <= out_row + 1'b1;
          out_slot <= (out_slot == SW'(SLOTS - 1)) ? '0 : out_slot + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_TILE_LAST: begin
            tile_last <= cfg_data[POS_W-1:0];
            in_row <= '0; in_col <= '0; in_slot <= '0;
            out_row <= '0; out_col <= '0; out_slot <= '0;
            tile_loaded <= 1'b0;
          end
          CFG_SPACE_SCALE: space_scale <= cfg_data[SPACE_W-1:0];
          CFG_COLOR_SCALE: color_scale <= cfg_data[COLOR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // capture pixel to filter
  always_ff @(posedge clk) begin
    if (emit) begin
      f_row  <= out_row;
      f_col  <= out_col;
      f_slot <= out_slot;
      f_done <= out_end;
    end
  end

  // tap sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      tv <= '0;
      tu <= '0;
      v0 <= 1'b0;
    end else begin
      v0 <= (state == ST_TAPS);
      if (state == ST_TAPS) begin
        if (tu == SW'(WIN - 1)) begin
          tu <= '0;
          tv <= tap_last ? '0 : tv + 1'b1;
        end else begin
          tu <= tu + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    dist0 <= tap_dist;
    if (state == ST_TAPS && tv == '0 && tu == '0) begin
      ctr <= ring_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0; vb <= 1'b0; vc <= 1'b0; vd <= 1'b0; ve <= 1'b0;
      vf <= 1'b0; vg <= 1'b0; vh <= 1'b0; vi <= 1'b0;
    end else begin
      va <= v0; vb <= va; vc <= vb; vd <= vc; ve <= vd;
      vf <= ve; vg <= vf; vh <= vg; vi <= vh;
    end
  end

  assign pipe_busy = v0 | va | vb | vc | vd | ve | vf | vg | vh | vi;

  always_comb begin
    sfull  = (SP_W-5)'((sprod_a + SP_W'(32)) >> 6);
    x_full = 64'(cprod_c) + COLOR_HALF;
    r_e    = y_e - qc_e;
    q_e    = (EW+1)'(q0_e) + ((r_e >= YW'(COLOR_C)) ? (EW+1)'(1) : '0);
    c_ok   = !big_e && (q_e < (EW+1)'(EXP_DEPTH));
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sq_a[k] <= 32'(($signed({1'b0, ring_q[16*k +: 16]}) - $signed({1'b0, ctr[16*k +: 16]})) *
                     ($signed({1'b0, ring_q[16*k +: 16]}) - $signed({1'b0, ctr[16*k +: 16]})));
    end
    sprod_a <= SP_W'(dist0) * SP_W'(space_scale);
    nb_a    <= ring_q;

    d2_b   <= 34'(sq_a[0]) + 34'(sq_a[1]) + 34'(sq_a[2]);
    s_ok_b <= (32'(sfull) < EXP_DEPTH);
    sidx_b <= EW'(sfull);
    nb_b   <= nb_a;

    cprod_c <= 54'(d2_b) * 54'(color_scale);
    sidx_c  <= sidx_b;
    s_ok_c  <= s_ok_b;
    nb_c    <= nb_b;

    big_d  <= (x_full >= BIG_LIMIT);
    y_d    <= YW'(x_full >> 6);
    q0_d   <= EW'(x_full >> 38);
    sidx_d <= sidx_c;
    s_ok_d <= s_ok_c;
    nb_d   <= nb_c;

    qc_e   <= YW'(q0_d) * YW'(COLOR_C);
    y_e    <= y_d;
    q0_e   <= q0_d;
    big_e  <= big_d;
    sidx_e <= sidx_d;
    s_ok_e <= s_ok_d;
    nb_e   <= nb_d;

    exp_s_f <= s_ok_e ? EXP_ROM[sidx_e] : '0;
    exp_c_f <= c_ok ? EXP_ROM[EW'(q_e)] : '0;
    nb_f    <= nb_e;

    wprod_g <= 34'(exp_s_f) * 34'(exp_c_f);
    nb_g    <= nb_f;

    w_h  <= 17'((wprod_g + 34'd32768) >> 16);
    nb_h <= nb_g;

    for (int k = 0; k < 4; k++) begin
      prod_i[k] <= 33'(w_h) * 33'(nb_h[16*k +: 16]);
    end
    w_i <= w_h;
  end

  // accumulate
  always_ff @(posedge clk) begin
    if (state == ST_CENTER) begin
      for (int k = 0; k < 4; k++) begin
        sum_acc[k] <= '0;
      end
      wsum <= '0;
    end else if (vi) begin
      for (int k = 0; k < 4; k++) begin
        sum_acc[k] <= sum_acc[k] + SUM_W'(prod_i[k]);
      end
      wsum <= wsum + WS'(w_i);
    end
  end

  // normalizing divide, four lanes
  always_comb begin
    wfl = (wsum == '0) ? WS'(1) : wsum;
    for (int k = 0; k < 4; k++) begin
      n_val[k] = NW'(sum_acc[k]) + NW'(wfl >> 1);
      rem2[k]  = {rem[k], nlow[k][CH_W-1]};
      ge[k]    = (rem2[k] >= {1'b0, dw});
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIV_INIT) begin
      dw      <= wfl;
      div_cnt <= '0;
      for (int k = 0; k < 4; k++) begin
        sat[k]  <= (n_val[k] >= NW'({wfl, 16'h0000}));
        rem[k]  <= WS'(n_val[k] >> 16);
        nlow[k] <= n_val[k][CH_W-1:0];
        quot[k] <= '0;
      end
    end else if (state == ST_DIV) begin
      div_cnt <= div_cnt + 1'b1;
      for (int k = 0; k < 4; k++) begin
        rem[k]  <= WS'(ge[k] ? rem2[k] - {1'b0, dw} : rem2[k]);
        quot[k] <= {quot[k][CH_W-2:0], ge[k]};
        nlow[k] <= {nlow[k][CH_W-2:0], 1'b0};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_go) begin
      out_red   <= sat[0] ? CHAN_MAX : quot[0];
      out_green <= sat[1] ? CHAN_MAX : quot[1];
      out_blue  <= sat[2] ? CHAN_MAX : quot[2];
      out_alpha <= sat[3] ? CHAN_MAX : quot[3];
      pixel_row <= f_row;
      pixel_col <= f_col;
      tile_done <= f_done;
    end
  end

  `CHK_IMPLY(a_drained, state == ST_DIV_INIT, !pipe_busy, "divide started with taps in flight")
  `CHK_IMPLY(a_center_w, state == ST_DIV_INIT, wsum >= WS'(65536), "center tap weight missing")
  `CHK_IMPLY(a_loaded, tile_loaded, (in_row == '0) && (in_col == '0), "write position not reset")

endmodule
`default_nettype wire

FILE: test/bilateral_filter_rgba_tile_top_tb.sv
`timescale 1ns / 1ps
module bilateral_filter_rgba_tile_top_tb;
  import bft_pkg::*;

  localparam int RADIUS = 4;
  localparam int RING_SIZE = 2304;
  localparam int TABLE_SIZE = 1024;
  localparam logic [63:0] COLOR_DIVISOR = 64'd65535 * 64'd65535 * 64'd64;

  typedef struct {
    logic            kind;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } pixel_item_t;

  typedef struct {
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  alpha;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             done;
  } filtered_pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = 1'b0;
  logic [CH_W-1:0] red = '0, green = '0, blue = '0, alpha = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CH_W-1:0] out_red, out_green, out_blue, out_alpha;
  logic [POS_W-1:0] pixel_row, pixel_col;
  logic tile_done;

  bilateral_filter_rgba_tile_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
    .red(red), .green(green), .blue(blue), .alpha(alpha),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue), .out_alpha(out_alpha),
    .pixel_row(pixel_row), .pixel_col(pixel_col), .tile_done(tile_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pixel_item_t pending_items[$];
  filtered_pixel_t expected_pixels[$];
  pixel_item_t cur_item;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic hold_off = 1'b0;
  int errors = 0;
  int pixels_checked = 0;
  int tiles_done = 0;
  int items_queued = 0;

  logic [31:0] exp_tab [TABLE_SIZE];
  logic [63:0] ring [RING_SIZE];
  int unsigned tile_last_reg, space_reg, color_reg;
  int unsigned wr_row, wr_col, rd_row, rd_col;
  bit loaded;

  function automatic int unsigned last_index();
    return tile_last_reg > 255 ? 255 : tile_last_reg;
  endfunction

  function automatic int unsigned ring_slot(int unsigned r, int unsigned c);
    return (r * (last_index() + 1) + c) % RING_SIZE;
  endfunction

  function automatic logic [63:0] exp_of(logic [63:0] idx);
    return idx < TABLE_SIZE ? 64'(exp_tab[idx]) : 64'd0;
  endfunction

  function automatic int unsigned clamp_to_tile(int v);
    if (v < 0) return 0;
    if (v > int'(last_index())) return last_index();
    return v;
  endfunction

  function automatic void filter_next(output filtered_pixel_t fp);
    logic [63:0] ctr, nb, d2, sidx, cidx, w, wsum, v;
    logic [63:0] acc [4];
    longint d;
    int unsigned lst;
    lst = last_index();
    ctr = ring[ring_slot(rd_row, rd_col)];
    wsum = 0;
    for (int k = 0; k < 4; k++) acc[k] = 0;
    for (int dv = -RADIUS; dv <= RADIUS; dv++) begin
      for (int du = -RADIUS; du <= RADIUS; du++) begin
        nb = ring[ring_slot(clamp_to_tile(int'(rd_row) + dv), clamp_to_tile(int'(rd_col) + du))];
        d2 = 0;
        for (int k = 0; k < 3; k++) begin
          d = longint'(nb[16*k +: 16]) - longint'(ctr[16*k +: 16]);
          d2 += 64'(d * d);
        end
        sidx = (64'(du * du + dv * dv) * 64'(space_reg) + 64'd32) >> 6;
        cidx = (d2 * 64'(color_reg) + COLOR_DIVISOR / 2) / COLOR_DIVISOR;
        w = (exp_of(sidx) * exp_of(cidx) + 64'd32768) >> 16;
        for (int k = 0; k < 4; k++) acc[k] += w * 64'(nb[16*k +: 16]);
        wsum += w;
      end
    end
    if (wsum < 1) wsum = 1;
    v = (acc[0] + wsum / 2) / wsum; fp.red   = v > 65535 ? CHAN_MAX : v[15:0];
    v = (acc[1] + wsum / 2) / wsum; fp.green = v > 65535 ? CHAN_MAX : v[15:0];
    v = (acc[2] + wsum / 2) / wsum; fp.blue  = v > 65535 ? CHAN_MAX : v[15:0];
    v = (acc[3] + wsum / 2) / wsum; fp.alpha = v > 65535 ? CHAN_MAX : v[15:0];
    fp.row = rd_row[7:0];
    fp.col = rd_col[7:0];
    fp.done = (rd_row == lst) && (rd_col == lst);
    if (fp.done) begin
      wr_row = 0; wr_col = 0; rd_row = 0; rd_col = 0; loaded = 0;
    end else if (rd_col >= lst) begin
      rd_col = 0; rd_row++;
    end else begin
      rd_col++;
    end
    expected_pixels.push_back(fp);
  endfunction

  function automatic void predict_transfer(pixel_item_t it);
    filtered_pixel_t fp;
    int unsigned lst, s, pos;
    lst = last_index();
    s = lst + 1;
    if (it.kind) begin
      if (loaded) filter_next(fp);
      return;
    end
    if (loaded) return;
    ring[ring_slot(wr_row, wr_col)] = {it.alpha, it.blue, it.green, it.red};
    pos = wr_row * s + wr_col;
    if (pos == s * s - 1) begin
      loaded = 1; wr_row = 0; wr_col = 0;
    end else if (wr_col >= lst) begin
      wr_col = 0; wr_row++;
    end else begin
      wr_col++;
    end
    if (pos >= RADIUS * s + RADIUS) filter_next(fp);
  endfunction

  function automatic void apply_reg(cfg_reg_t idx, int unsigned value);
    case (idx)
      CFG_TILE_LAST: begin
        tile_last_reg = value & 32'hFF;
        wr_row = 0; wr_col = 0; rd_row = 0; rd_col = 0; loaded = 0;
      end
      CFG_SPACE_SCALE: space_reg = value & 32'hFFFF;
      CFG_COLOR_SCALE: color_reg = value & 32'hFFFFF;
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_transfer(cur_item);
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item = pending_items.pop_front();
          kind <= cur_item.kind;
          red <= cur_item.red;
          green <= cur_item.green;
          blue <= cur_item.blue;
          alpha <= cur_item.alpha;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    filtered_pixel_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected pixel row", pixel_row, -1);
        end else begin
          e = expected_pixels.pop_front();
          if (out_red !== e.red) report_mismatch("out_red", out_red, e.red);
          if (out_green !== e.green) report_mismatch("out_green", out_green, e.green);
          if (out_blue !== e.blue) report_mismatch("out_blue", out_blue, e.blue);
          if (out_alpha !== e.alpha) report_mismatch("out_alpha", out_alpha, e.alpha);
          if (pixel_row !== e.row) report_mismatch("pixel_row", pixel_row, e.row);
          if (pixel_col !== e.col) report_mismatch("pixel_col", pixel_col, e.col);
          if (tile_done !== e.done) report_mismatch("tile_done", tile_done, e.done);
          pixels_checked++;
          if (e.done) tiles_done++;
        end
      end
      out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_reg(cfg_reg_t idx, int unsigned value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, value);
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || expected_pixels.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic void queue_item(bit k, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                     logic [CH_W-1:0] b, logic [CH_W-1:0] a);
    pixel_item_t it;
    it.kind = k; it.red = r; it.green = g; it.blue = b; it.alpha = a;
    pending_items.push_back(it);
    items_queued++;
  endfunction

  function automatic logic [CH_W-1:0] near_value(logic [CH_W-1:0] base, int unsigned spread);
    int v;
    v = int'(base) + int'($urandom_range(2 * spread)) - int'(spread);
    return v < 0 ? 16'd0 : (v > 65535 ? CHAN_MAX : v[15:0]);
  endfunction

  // style 0: random, 1: smooth around a base, 2: two flat regions split by an edge
  function automatic void queue_tile(int unsigned lst, int unsigned style);
    int unsigned s, flush;
    logic [CH_W-1:0] base [4];
    logic [CH_W-1:0] other [4];
    logic [CH_W-1:0] px [4];
    s = lst + 1;
    flush = (s * s < RADIUS * s + RADIUS) ? s * s : RADIUS * s + RADIUS;
    for (int k = 0; k < 4; k++) begin
      base[k] = $urandom;
      other[k] = $urandom;
    end
    for (int r = 0; r < s; r++) begin
      for (int c = 0; c < s; c++) begin
        for (int k = 0; k < 4; k++) begin
          case (style)
            0: px[k] = $urandom;
            1: px[k] = near_value(base[k], 3000);
            default: px[k] = near_value(c > r ? base[k] : other[k], 500);
          endcase
        end
        if ($urandom_range(19) == 0) queue_item(1'b1, $urandom, $urandom, $urandom, $urandom);
        queue_item(1'b0, px[0], px[1], px[2], px[3]);
      end
    end
    if ($urandom_range(3) == 0) queue_item(1'b0, $urandom, $urandom, $urandom, $urandom);
    for (int i = 0; i < flush; i++) queue_item(1'b1, $urandom, $urandom, $urandom, $urandom);
    if ($urandom_range(3) == 0) queue_item(1'b1, $urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic random_scales();
    int unsigned pick;
    pick = $urandom_range(5);
    if (pick == 0) write_reg(CFG_SPACE_SCALE, 0);
    else if (pick == 1) write_reg(CFG_SPACE_SCALE, 65535);
    else if (pick == 2) write_reg(CFG_SPACE_SCALE, $urandom_range(8000));
    pick = $urandom_range(5);
    if (pick == 0) write_reg(CFG_COLOR_SCALE, 0);
    else if (pick == 1) write_reg(CFG_COLOR_SCALE, 1048575);
    else if (pick == 2) write_reg(CFG_COLOR_SCALE, $urandom_range(400000));
  endtask

  initial begin
    logic [63:0] a;
    int unsigned idle_modes [4] = '{0, 74, 0, 33};
    int unsigned stall_modes [4] = '{0, 0, 74, 33};
    int unsigned lst, target;
    a = 64'd1 << 30;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      exp_tab[i] = 32'((a + 64'd8192) >> 14);
      a = (a * 64'd1057095000 + (64'd1 << 29)) >> 30;
    end
    for (int i = 0; i < RING_SIZE; i++) ring[i] = '0;
    tile_last_reg = 63; space_reg = 1693; color_reg = 80000;
    wr_row = 0; wr_col = 0; rd_row = 0; rd_col = 0; loaded = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // single-pixel tile, all ones, then an idle drain
    write_reg(CFG_TILE_LAST, 0);
    queue_item(1'b1, 16'h1234, 16'h0, 16'h0, 16'h0);
    queue_item(1'b0, CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX);
    queue_item(1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
    queue_item(1'b1, 16'h0, 16'h0, 16'h0, 16'h0);
    queue_item(1'b1, CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX);
    wait_idle();
    // 2x2 tile of extremes with an early pixel before the flush
    write_reg(CFG_TILE_LAST, 1);
    write_reg(CFG_COLOR_SCALE, 1048575);
    queue_item(1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
    queue_item(1'b0, CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX);
    queue_item(1'b0, CHAN_MAX, 16'h0, CHAN_MAX, 16'h0);
    queue_item(1'b0, 16'h0, CHAN_MAX, 16'h0, CHAN_MAX);
    queue_item(1'b0, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    for (int i = 0; i < 4; i++) queue_item(1'b1, 16'h0, 16'h0, 16'h0, 16'h0);
    wait_idle();
    write_reg(CFG_SPACE_SCALE, 0);
    write_reg(CFG_COLOR_SCALE, 0);
    write_reg(CFG_TILE_LAST, 2);
    queue_tile(2, 0);
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_modes[p];
      recv_stall_pct = stall_modes[p];
      target = items_queued + 80;
      if (p == 0) begin
        write_reg(CFG_TILE_LAST, 6);
        write_reg(CFG_SPACE_SCALE, 1693);
        write_reg(CFG_COLOR_SCALE, 80000);
        queue_tile(6, 1);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (1500) @(posedge clk);
        hold_off <= 1'b0;
        wait_idle();
      end
      if (p == 3) begin
        // largest tile: load part of it, then abandon it
        write_reg(CFG_TILE_LAST, 255);
        for (int i = 0; i < 30; i++) queue_item(1'b0, $urandom, $urandom, $urandom, $urandom);
        wait_idle();
      end
      while (items_queued < target) begin
        lst = ($urandom_range(9) == 0) ? $urandom_range(1, 8) : $urandom_range(2, 6);
        write_reg(CFG_TILE_LAST, lst);
        random_scales();
        queue_tile(lst, $urandom_range(2));
        wait_idle();
      end
    end

    $display("checked %0d filtered pixels over %0d completed tiles from %0d input items",
             pixels_checked, tiles_done, items_queued);
    $display("tile sizes 1 to 9 and 256, scale extremes, four idle/stall mixes");
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("bilateral_filter_rgba_tile_top_tb OK");
    end else begin
      $display("bilateral_filter_rgba_tile_top_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("timeout with %0d pixels still expected", expected_pixels.size());
    $display("bilateral_filter_rgba_tile_top_tb NOT OK");
    $finish;
  end

endmodule
